>>> rtl/mies_pkg.sv
// Package for the MIPS integer execute step: sizes, opcode and function codes,
// item kinds and the controller state type. Used by mips_integer_execute_step.
// No dependencies.
`default_nettype none

package mies_pkg;

    // Data memory depth in words (power of two) and its index width
    localparam int MEM_WORDS = 256;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // Register file
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = 5;
    localparam logic [RF_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [RF_AW-1:0] REG_V0   = 5'd2;
    localparam logic [RF_AW-1:0] REG_A0   = 5'd4;
    localparam logic [RF_AW-1:0] REG_SP   = 5'd29;
    localparam logic [RF_AW-1:0] REG_RA   = 5'd31;

    localparam logic [31:0] SP_RESET = 32'd255;

    // Iterative divider
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Item kinds
    localparam logic [1:0] KIND_EXEC    = 2'd0;
    localparam logic [1:0] KIND_READINT = 2'd1;
    localparam logic [1:0] KIND_PRELOAD = 2'd2;

    // Syscall request kinds
    localparam logic [1:0] SYS_NONE  = 2'd0;
    localparam logic [1:0] SYS_PRINT = 2'd1;
    localparam logic [1:0] SYS_READ  = 2'd2;
    localparam logic [31:0] V0_PRINT = 32'd1;
    localparam logic [31:0] V0_READ  = 32'd5;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes of the special opcode
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    // Word widths on the stream ports
    localparam int IN_DW  = 72;
    localparam int OUT_DW = 104;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_EXEC,
        S_DIV,
        S_DFIX,
        S_LOAD,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

>>> rtl/mies_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mies_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/mips_integer_execute_step.sv
// Top level of the MIPS integer execute step: controller, ALU, multiplier,
// iterative divider, register file and data memory.
// Depends on mies_pkg and mies_ram.
//
//  Channel   Ports                    Dir  Payload
//  item in   i_s_axis_* / o_s_axis_*  in   tuser kind, tdata instruction/value/address
//  result    o_m_axis_* / i_m_axis_*  out  tuser syscall_kind, tdata rest
//  config    i_cfg_* / o_cfg_ready    in   stack_pointer_reset
//
// An item passes RDA, RDB, EXEC and FIN before the output register is loaded;
// lw adds LOAD, and div and divu with a nonzero divisor add DIV and DFIX for
// the one-bit-per-cycle restoring divider; the next item is accepted in IDLE.
// The register file is read over one port, rs then rt.
// Reset (synchronous, active low) clears control, PC, HI, LO and the valid
// bits of the register file; an invalid register reads as zero, or as the
// stack pointer reset value for register 29. A finished item waits in its
// last state while the output register holds an unaccepted word.
`default_nettype none

module mips_integer_execute_step (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] instruction, [63:32] input_value, [71:64] load_address
    input  wire logic [mies_pkg::IN_DW-1:0] i_s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]                 i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // [31:0] next_pc, [32] reg_written, [37:33] write_index,
    // [69:38] write_value, [70] overflow, [102:71] print_value, [103] zero
    output logic [mies_pkg::OUT_DW-1:0]     o_m_axis_tdata,
    // [1:0] syscall_kind
    output logic [1:0]                      o_m_axis_tuser,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [31:0]                i_cfg_data
);

    import mies_pkg::*;

    t_state r_state, n_state;

    // Captured item
    logic [1:0]  r_kind;
    logic [31:0] r_ins, r_val;
    logic [7:0]  r_laddr;

    // Architectural state in flops
    logic [31:0] r_pc, r_hi, r_lo, r_sp;
    logic [RF_DEPTH-1:0] r_rf_vld;

    // Operand and result holding
    logic [31:0]      r_a;
    logic             r_rd_vld, r_rd_sp;
    logic [31:0]      r_res_pc, r_res_val, r_res_pv;
    logic             r_res_wr, r_res_ovf;
    logic [RF_AW-1:0] r_res_idx;
    logic [1:0]       r_res_sk;

    // Output register
    logic        r_ovld;
    logic [31:0] r_o_pc, r_o_val, r_o_pv;
    logic        r_o_wr, r_o_ovf;
    logic [4:0]  r_o_idx;
    logic [1:0]  r_o_sk;

    // Divider
    logic [31:0]       r_drem, r_dquo, r_ddiv;
    logic              r_dneg_q, r_dneg_r;
    logic [DIV_CW-1:0] r_dcnt;

    // Decode
    logic [5:0]       op, funct;
    logic [RF_AW-1:0] rs, rt, rd;
    logic [4:0]       sa;
    logic [31:0]      imm, simm, pc4;
    logic             is_sys;

    assign op     = r_ins[31:26];
    assign rs     = r_ins[25:21];
    assign rt     = r_ins[20:16];
    assign rd     = r_ins[15:11];
    assign sa     = r_ins[10:6];
    assign funct  = r_ins[5:0];
    assign imm    = {16'd0, r_ins[15:0]};
    assign simm   = {{16{r_ins[15]}}, r_ins[15:0]};
    assign pc4    = r_pc + 32'd4;
    assign is_sys = (op == OP_SPECIAL) && (funct == FN_SYSCALL);

    // Register file
    logic             rf_we;
    logic [RF_AW-1:0] rf_raddr;
    logic [31:0]      rf_raw, rf_rd;

    assign rf_raddr = (r_state == S_RDA) ? (is_sys ? REG_V0 : rs)
                                         : (is_sys ? REG_A0 : rt);
    assign rf_rd    = r_rd_vld ? rf_raw : (r_rd_sp ? r_sp : 32'd0);

    mies_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_res_idx),
        .i_wdata (r_res_val),
        .i_raddr (rf_raddr),
        .o_rdata (rf_raw)
    );

    // Data memory
    logic              dm_we;
    logic [MEM_AW-1:0] dm_waddr, dm_raddr;
    logic [31:0]       dm_wdata, dm_rdata;

    mies_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dm (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (dm_raddr),
        .o_rdata (dm_rdata)
    );

    // Handshakes
    logic in_acc, out_free, fin_go;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovld || i_m_axis_tready;
    assign fin_go          = (r_state == S_FIN) && out_free;
    assign o_cfg_ready     = 1'b1;
    assign rf_we           = fin_go && r_res_wr;

    // Execute datapath
    logic [31:0]      e_a, e_b, e_pc, e_val, e_pv, e_sum, e_dif, e_mad, e_hi, e_lo;
    logic             e_want, e_wr, e_ovf, e_hi_we, e_lo_we, e_mul_s;
    logic             e_div, e_load;
    logic [RF_AW-1:0] e_idx;
    logic [1:0]       e_sk;
    logic [31:0]      la32;
    logic [65:0]      e_prod;

    assign e_a     = r_a;
    assign e_b     = rf_rd;
    assign e_sum   = e_a + e_b;
    assign e_dif   = e_a - e_b;
    assign e_mad   = e_a + simm;
    assign la32    = {24'd0, r_laddr};
    assign e_mul_s = (funct == FN_MULT);
    assign e_prod  = $signed({e_mul_s & e_a[31], e_a}) * $signed({e_mul_s & e_b[31], e_b});

    always_comb begin
        e_pc     = r_pc;
        e_want   = 1'b0;
        e_idx    = REG_ZERO;
        e_val    = 32'd0;
        e_ovf    = 1'b0;
        e_sk     = SYS_NONE;
        e_pv     = 32'd0;
        e_hi_we  = 1'b0;
        e_lo_we  = 1'b0;
        e_hi     = 32'd0;
        e_lo     = 32'd0;
        e_div    = 1'b0;
        e_load   = 1'b0;
        dm_we    = 1'b0;
        dm_waddr = e_mad[MEM_AW+1:2];
        dm_wdata = e_b;
        dm_raddr = e_mad[MEM_AW+1:2];
        case (r_kind)
            KIND_EXEC: begin
                e_pc = pc4;
                case (op)
                    OP_SPECIAL: begin
                        e_idx = rd;
                        case (funct)
                            FN_ADD: begin
                                e_ovf  = (e_a[31] ^ e_sum[31]) & (e_b[31] ^ e_sum[31]);
                                e_want = !e_ovf;
                                e_val  = e_sum;
                            end
                            FN_ADDU: begin e_want = 1'b1; e_val = e_sum; end
                            FN_SUB: begin
                                e_ovf  = (e_a[31] ^ e_b[31]) & (e_a[31] ^ e_dif[31]);
                                e_want = !e_ovf;
                                e_val  = e_dif;
                            end
                            FN_SUBU: begin e_want = 1'b1; e_val = e_dif; end
                            FN_SLT: begin
                                e_want = 1'b1;
                                e_val  = {31'd0, $signed(e_a) < $signed(e_b)};
                            end
                            FN_SLTU: begin e_want = 1'b1; e_val = {31'd0, e_a < e_b}; end
                            FN_AND:  begin e_want = 1'b1; e_val = e_a & e_b; end
                            FN_OR:   begin e_want = 1'b1; e_val = e_a | e_b; end
                            FN_XOR:  begin e_want = 1'b1; e_val = e_a ^ e_b; end
                            FN_NOR:  begin e_want = 1'b1; e_val = ~(e_a | e_b); end
                            FN_SLL:  begin e_want = 1'b1; e_val = e_b << sa; end
                            FN_SRL:  begin e_want = 1'b1; e_val = e_b >> sa; end
                            FN_SRA: begin
                                e_want = 1'b1;
                                e_val  = 32'($signed(e_b) >>> sa);
                            end
                            FN_SLLV: begin e_want = 1'b1; e_val = e_b << e_a[4:0]; end
                            FN_SRLV: begin e_want = 1'b1; e_val = e_b >> e_a[4:0]; end
                            FN_SRAV: begin
                                e_want = 1'b1;
                                e_val  = 32'($signed(e_b) >>> e_a[4:0]);
                            end
                            FN_MULT, FN_MULTU: begin
                                e_hi_we = 1'b1;
                                e_lo_we = 1'b1;
                                e_hi    = e_prod[63:32];
                                e_lo    = e_prod[31:0];
                            end
                            FN_DIV, FN_DIVU: begin
                                // zero divisor clears HI and LO at once
                                if (e_b == 32'd0) begin
                                    e_hi_we = 1'b1;
                                    e_lo_we = 1'b1;
                                end else begin
                                    e_div = 1'b1;
                                end
                            end
                            FN_MFHI: begin e_want = 1'b1; e_val = r_hi; end
                            FN_MFLO: begin e_want = 1'b1; e_val = r_lo; end
                            FN_MTHI: begin e_hi_we = 1'b1; e_hi = e_a; end
                            FN_MTLO: begin e_lo_we = 1'b1; e_lo = e_a; end
                            FN_JR:   e_pc = e_a;
                            FN_JALR: begin
                                e_pc   = e_a;
                                e_want = 1'b1;
                                e_val  = pc4;
                            end
                            FN_SYSCALL: begin
                                // operands here are $v0 and $a0
                                if (e_a == V0_PRINT) begin
                                    e_sk = SYS_PRINT;
                                    e_pv = e_b;
                                end else if (e_a == V0_READ) begin
                                    e_sk = SYS_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                    OP_J, OP_JAL: begin
                        e_pc   = {8'd0, r_ins[25:2]};
                        e_want = (op == OP_JAL);
                        e_idx  = REG_RA;
                        e_val  = pc4;
                    end
                    OP_LW: begin
                        e_want = 1'b1;
                        e_idx  = rt;
                        e_load = 1'b1;
                    end
                    OP_SW: dm_we = 1'b1;
                    OP_ADDI: begin
                        e_idx  = rt;
                        e_ovf  = (e_a[31] ^ e_mad[31]) & (simm[31] ^ e_mad[31]);
                        e_want = !e_ovf;
                        e_val  = e_mad;
                    end
                    OP_ADDIU: begin e_want = 1'b1; e_idx = rt; e_val = e_mad; end
                    OP_ORI:   begin e_want = 1'b1; e_idx = rt; e_val = e_a | imm; end
                    OP_XORI:  begin e_want = 1'b1; e_idx = rt; e_val = e_a ^ imm; end
                    OP_LUI: begin
                        e_want = 1'b1;
                        e_idx  = rt;
                        e_val  = {r_ins[15:0], 16'd0};
                    end
                    OP_SLTI: begin
                        e_want = 1'b1;
                        e_idx  = rt;
                        e_val  = {31'd0, $signed(e_a) < $signed(simm)};
                    end
                    OP_SLTIU: begin
                        e_want = 1'b1;
                        e_idx  = rt;
                        e_val  = {31'd0, e_a < simm};
                    end
                    OP_BEQ:  if (e_a == e_b) e_pc = pc4 + simm;
                    OP_BNE:  if (e_a != e_b) e_pc = pc4 + simm;
                    OP_BLEZ: if (e_a == 32'd0 || e_a[31]) e_pc = pc4 + simm;
                    OP_BGTZ: if (e_a != 32'd0 && !e_a[31]) e_pc = pc4 + simm;
                    default: ;
                endcase
            end
            KIND_READINT: begin
                e_want = 1'b1;
                e_idx  = REG_V0;
                e_val  = r_val;
            end
            KIND_PRELOAD: begin
                dm_we    = 1'b1;
                dm_waddr = la32[MEM_AW-1:0];
                dm_wdata = r_val;
            end
            default: e_pc = r_pc;
        endcase
        // stores and preloads only in the execute cycle
        dm_we = dm_we && (r_state == S_EXEC);
    end

    // Register zero is never written
    assign e_wr = e_want && (e_idx != REG_ZERO);

    // One restoring divide step
    logic [32:0] d_t, d_sub;
    logic        d_ge;
    assign d_t   = {r_drem, r_dquo[31]};
    assign d_sub = d_t - {1'b0, r_ddiv};
    assign d_ge  = !d_sub[32];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_EXEC;
            S_EXEC: begin
                if (e_div) begin
                    n_state = S_DIV;
                end else if (e_load) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV:   if (r_dcnt == DIV_CW'(DIV_STEPS - 1)) n_state = S_DFIX;
            S_DFIX:  n_state = S_FIN;
            S_LOAD:  n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= 32'd0;
            r_hi     <= 32'd0;
            r_lo     <= 32'd0;
            r_sp     <= SP_RESET;
            r_rf_vld <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_pc <= e_pc;
                if (e_hi_we) r_hi <= e_hi;
                if (e_lo_we) r_lo <= e_lo;
            end
            // apply signs to the divide result
            if (r_state == S_DFIX) begin
                r_lo <= r_dneg_q ? (32'd0 - r_dquo) : r_dquo;
                r_hi <= r_dneg_r ? (32'd0 - r_drem) : r_drem;
            end
            if (rf_we) r_rf_vld[r_res_idx] <= 1'b1;
            if (fin_go) begin
                r_ovld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            // a new stack pointer reset also reloads register 29
            if (i_cfg_valid) begin
                r_sp              <= i_cfg_data;
                r_rf_vld[REG_SP]  <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_s_axis_tuser;
            r_ins   <= i_s_axis_tdata[31:0];
            r_val   <= i_s_axis_tdata[63:32];
            r_laddr <= i_s_axis_tdata[71:64];
        end
        r_rd_vld <= r_rf_vld[rf_raddr];
        r_rd_sp  <= (rf_raddr == REG_SP);
        if (r_state == S_RDB) r_a <= rf_rd;
        if (r_state == S_EXEC) begin
            r_res_pc  <= e_pc;
            r_res_wr  <= e_wr;
            r_res_idx <= e_wr ? e_idx : REG_ZERO;
            r_res_val <= e_wr ? e_val : 32'd0;
            r_res_ovf <= e_ovf;
            r_res_sk  <= e_sk;
            r_res_pv  <= e_pv;
            // load the divider with magnitudes
            r_drem   <= 32'd0;
            r_dcnt   <= '0;
            r_ddiv   <= (funct == FN_DIV && e_b[31]) ? (32'd0 - e_b) : e_b;
            r_dquo   <= (funct == FN_DIV && e_a[31]) ? (32'd0 - e_a) : e_a;
            r_dneg_q <= (funct == FN_DIV) && (e_a[31] != e_b[31]);
            r_dneg_r <= (funct == FN_DIV) && e_a[31];
        end
        if (r_state == S_DIV) begin
            r_drem <= d_ge ? d_sub[31:0] : d_t[31:0];
            r_dquo <= {r_dquo[30:0], d_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (r_state == S_LOAD && r_res_wr) r_res_val <= dm_rdata;
        if (fin_go) begin
            r_o_pc  <= r_res_pc;
            r_o_wr  <= r_res_wr;
            r_o_idx <= r_res_idx;
            r_o_val <= r_res_val;
            r_o_ovf <= r_res_ovf;
            r_o_sk  <= r_res_sk;
            r_o_pv  <= r_res_pv;
        end
    end

    // Result word
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {1'b0, r_o_pv, r_o_ovf, r_o_val, r_o_idx, r_o_wr, r_o_pc};
    assign o_m_axis_tuser  = r_o_sk;

    // Checks
    a_ovf_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && e_ovf) |=> !r_res_wr)
        else $error("overflow with register write");
    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (r_res_idx != REG_ZERO))
        else $error("write to register zero");
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RDA))
        else $error("accepted word not taken into read phase");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_dcnt == DIV_CW'(DIV_STEPS - 1)) |=> (r_state == S_DFIX))
        else $error("divider did not finish");
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_state == S_IDLE && !r_ovld))
        else $error("not idle after reset");

endmodule

`default_nettype wire
